>>> design/vahd_pkg.sv
// Package for the averaging voltmeter with hysteresis and display driver.
// Holds widths, reset values, division constants and shared types.
// No dependencies.
`default_nettype none

package vahd_pkg;

    localparam int unsigned SAMPLES_DEF = 6;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned SUM_W    = 13;
    localparam int unsigned VOLT_W   = 12;
    localparam int unsigned BAND_W   = 8;
    localparam int unsigned OFFS_W   = 6;
    localparam int unsigned SCALE_W  = 12;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BAND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;

    localparam logic [BAND_W-1:0]  BAND_RST   = 8'd3;
    localparam logic [OFFS_W-1:0]  OFFSET_RST = 6'd3;
    localparam logic [SCALE_W-1:0] SCALE_RST  = 12'd2500;

    localparam logic [VOLT_W-1:0] VOLT_MAX = 12'd4095;

    // item kinds on s_tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // reciprocal shift for the group average
    localparam int unsigned AVG_SHIFT = 17;

    // reciprocal multipliers for decimal digit extraction (exact over range)
    localparam logic [12:0] DIV1000_MUL = 13'd4195;   // >> 22
    localparam logic [9:0]  DIV100_MUL  = 10'd656;    // >> 16
    localparam logic [6:0]  DIV10_MUL   = 7'd103;     // >> 10

    typedef struct packed {
        logic [3:0] digit_enable;
        logic [3:0] digit_value;
        logic [1:0] next_position;
    } disp_out_t;

endpackage

`default_nettype wire

>>> design/vahd_scaler.sv
// Two-stage scaler: group average by reciprocal multiply, then offset and scale.
// Saturates the result to the voltage range. Depends on vahd_pkg.
`default_nettype none

module vahd_scaler #(
    parameter int unsigned SAMPLES = vahd_pkg::SAMPLES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [vahd_pkg::SUM_W-1:0]    group_sum,
    input  wire logic [vahd_pkg::OFFS_W-1:0]   sample_offset,
    input  wire logic [vahd_pkg::SCALE_W-1:0]  scale_factor,
    input  wire logic                          take,
    output logic                               res_valid,
    output logic [vahd_pkg::VOLT_W-1:0]        res_value
);
    import vahd_pkg::*;

    localparam int unsigned RECIP_W = AVG_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES);
    localparam int unsigned QPROD_W = SUM_W + RECIP_W;
    localparam int unsigned ADJ_W   = SUM_W + 1;
    localparam int unsigned PROD_W  = ADJ_W + SCALE_W;

    logic [QPROD_W-1:0] qprod;
    logic [SUM_W-1:0]   quot_reg;
    logic               v1_reg;
    logic [ADJ_W-1:0]   adj;
    logic [PROD_W-1:0]  prod_reg;
    logic               v2_reg;
    logic [PROD_W-11:0] shifted;

    assign qprod = QPROD_W'(group_sum) * QPROD_W'(RECIP_MUL);
    assign adj   = ADJ_W'(quot_reg) + ADJ_W'(sample_offset);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            if (v1_reg) begin
                v2_reg <= 1'b1;
            end else if (take) begin
                v2_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= qprod[AVG_SHIFT +: SUM_W];
        end
        if (v1_reg) begin
            prod_reg <= PROD_W'(adj) * PROD_W'(scale_factor);
        end
    end

    assign shifted   = prod_reg[PROD_W-1:10];
    assign res_valid = v2_reg;
    assign res_value = (shifted > (PROD_W-10)'(VOLT_MAX)) ? VOLT_MAX : shifted[VOLT_W-1:0];

endmodule

`default_nettype wire

>>> design/vahd_digits.sv
// Display digit selection: splits the shown voltage into decimal digits and
// picks the lit position, skipping leading zeros above tens. Depends on vahd_pkg.
`default_nettype none

module vahd_digits (
    input  wire logic [vahd_pkg::VOLT_W-1:0] voltage,
    input  wire logic [1:0]                  position,
    output vahd_pkg::disp_out_t              disp
);
    import vahd_pkg::*;

    logic [24:0] th_prod;
    logic [3:0]  thousands;
    logic [9:0]  rem1;
    logic [19:0] hu_prod;
    logic [3:0]  hundreds;
    logic [6:0]  rem2;
    logic [13:0] te_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [1:0]  sel;

    always_comb begin
        th_prod   = 25'(voltage) * 25'(DIV1000_MUL);
        thousands = 4'(th_prod[24:22]);
        rem1      = 10'(voltage - 12'(thousands) * 12'd1000);
        hu_prod   = 20'(rem1) * 20'(DIV100_MUL);
        hundreds  = hu_prod[19:16];
        rem2      = 7'(rem1 - 10'(hundreds) * 10'd100);
        te_prod   = 14'(rem2) * 14'(DIV10_MUL);
        tens      = te_prod[13:10];
        ones      = 4'(rem2 - 7'(tens) * 7'd10);

        sel = position;
        if (position == 2'd0) begin
            if (thousands != 4'd0) begin
                sel = 2'd0;
            end else if (hundreds != 4'd0) begin
                sel = 2'd1;
            end else begin
                sel = 2'd2;
            end
        end

        case (sel)
            2'd0:    disp.digit_value = thousands;
            2'd1:    disp.digit_value = hundreds;
            2'd2:    disp.digit_value = tens;
            default: disp.digit_value = ones;
        endcase
        disp.digit_enable  = 4'b0001 << sel;
        disp.next_position = sel + 2'd1;
    end

endmodule

`default_nettype wire

>>> design/voltage_average_hysteresis_display.sv
// Averaging voltmeter with hysteresis-filtered reading and multiplexed display.
// Results are registered. Throughput: one item per cycle while m_tready allows,
// except a sample that closes a group, which holds the input register while
// the two-multiplier scaler runs.
// Reset (aresetn, synchronous, active low) clears state, config and handshakes.
// Depends on vahd_pkg, vahd_scaler, vahd_digits.
`default_nettype none

module voltage_average_hysteresis_display #(
    parameter int unsigned SAMPLES = vahd_pkg::SAMPLES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [vahd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vahd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [vahd_pkg::S_TDATA_W-1:0]    s_tdata,   // [9:0] adc_sample
    input  wire logic                              s_tuser,   // [0] op
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [11:0] measured_voltage, [12] voltage_changed, [16:13] digit_enable,
    // [20:17] digit_value, [23:21] zero
    output logic [vahd_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tuser    // [0] digit_valid
);
    import vahd_pkg::*;

    // configuration registers
    logic [BAND_W-1:0]  band_reg;
    logic [OFFS_W-1:0]  offset_reg;
    logic [SCALE_W-1:0] scale_reg;

    // input register
    logic                in_valid_reg;
    logic                in_op_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;

    // block state
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [VOLT_W-1:0]  shown_reg;
    logic [1:0]         position_reg;
    logic               busy_reg;

    // result register
    logic               out_valid_reg;
    logic [VOLT_W-1:0]  out_volt_reg;
    logic               out_changed_reg;
    logic [3:0]         out_enable_reg;
    logic [3:0]         out_digit_reg;
    logic               out_dvalid_reg;

    logic               out_free;
    logic               is_sample;
    logic [COUNT_W:0]   count_inc;
    logic               completes;
    logic [SUM_W-1:0]   sum_total;
    logic               launch;
    logic               consume;
    logic               take;
    logic               res_valid;
    logic [VOLT_W-1:0]  res_value;
    logic [VOLT_W:0]    upper;
    logic               outside;
    disp_out_t          disp;

    assign out_free  = !out_valid_reg || m_tready;
    assign is_sample = in_valid_reg && (in_op_reg == OP_SAMPLE);
    assign count_inc = (COUNT_W+1)'(count_reg) + (COUNT_W+1)'(1);
    assign completes = count_inc >= (COUNT_W+1)'(SAMPLES);
    assign sum_total = sum_reg + SUM_W'(in_sample_reg);
    assign launch    = is_sample && completes && !busy_reg;
    assign consume   = in_valid_reg && out_free &&
                       (in_op_reg == OP_TICK || !completes || res_valid);
    assign take      = consume && is_sample && completes;
    assign s_tready  = !in_valid_reg || consume;

    vahd_scaler #(
        .SAMPLES (SAMPLES)
    ) u_scaler (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (launch),
        .group_sum     (sum_total),
        .sample_offset (offset_reg),
        .scale_factor  (scale_reg),
        .take          (take),
        .res_valid     (res_valid),
        .res_value     (res_value)
    );

    vahd_digits u_digits (
        .voltage  (shown_reg),
        .position (position_reg),
        .disp     (disp)
    );

    // lower bound may go below zero, then nothing lies under it
    assign upper   = (VOLT_W+1)'(shown_reg) + (VOLT_W+1)'(band_reg);
    assign outside = ((VOLT_W+1)'(res_value) > upper) ||
                     ((shown_reg >= VOLT_W'(band_reg)) &&
                      (res_value < shown_reg - VOLT_W'(band_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg   <= BAND_RST;
            offset_reg <= OFFSET_RST;
            scale_reg  <= SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BAND:   band_reg   <= cfg_wdata[BAND_W-1:0];
                REG_OFFSET: offset_reg <= cfg_wdata[OFFS_W-1:0];
                REG_SCALE:  scale_reg  <= cfg_wdata[SCALE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_op_reg     <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            shown_reg    <= '0;
            position_reg <= '0;
            busy_reg     <= 1'b0;
        end else begin
            if (launch) begin
                busy_reg <= 1'b1;
            end
            if (consume) begin
                if (in_op_reg == OP_TICK) begin
                    position_reg <= disp.next_position;
                end else if (completes) begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    busy_reg  <= 1'b0;
                    if (outside) begin
                        shown_reg <= res_value;
                    end
                end else begin
                    count_reg <= count_inc[COUNT_W-1:0];
                    sum_reg   <= sum_total;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= consume;
        end
        if (consume) begin
            if (in_op_reg == OP_TICK) begin
                out_volt_reg    <= shown_reg;
                out_changed_reg <= 1'b0;
                out_enable_reg  <= disp.digit_enable;
                out_digit_reg   <= disp.digit_value;
                out_dvalid_reg  <= 1'b1;
            end else begin
                out_volt_reg    <= (completes && outside) ? res_value : shown_reg;
                out_changed_reg <= completes && outside;
                out_enable_reg  <= '0;
                out_digit_reg   <= '0;
                out_dvalid_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_dvalid_reg;
    assign m_tdata  = {3'b000, out_digit_reg, out_enable_reg, out_changed_reg, out_volt_reg};

`ifndef NO_ASSERTIONS
    a_busy_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> in_valid_reg && is_sample && completes)
        else $error("scaler busy without a group-closing sample held");

    a_result_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> busy_reg)
        else $error("scaler result without an owning sample");

    a_tick_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> $onehot(m_tdata[16:13]) && m_tdata[20:17] <= 4'd9
                                && !m_tdata[12])
        else $error("tick result with bad digit select or value");

    a_sample_no_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[20:13] == 8'd0)
        else $error("sample result drives a digit");

    a_shown_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(shown_reg) |-> $past(take))
        else $error("shown voltage changed outside a group close");
`endif

endmodule

`default_nettype wire
